@@ design/wsmm_pkg.sv @@
`default_nettype none

package wsmm_pkg;

    localparam int SAMPLE_W    = 16;
    localparam int SUM_W       = 22;
    localparam int POS_W       = 16;
    localparam int CFG_W       = 7;
    localparam int LEN_MIN     = 2;
    localparam int CFG_RESET   = 2;
    localparam int OUT_FIELD_W = 2 * SUM_W + 2 * POS_W;
    localparam int OUT_TDATA_W = ((OUT_FIELD_W + 7) / 8) * 8;

    // one accepted word after the running sum update
    typedef struct packed {
        logic                    valid;
        logic                    last;
        logic                    err;
        logic                    win;
        logic [POS_W-1:0]        start;
        logic signed [SUM_W-1:0] sum;
    } t_win_item;

    typedef struct packed {
        logic signed [SUM_W-1:0] max_sum;
        logic [POS_W-1:0]        max_start;
        logic signed [SUM_W-1:0] min_sum;
        logic [POS_W-1:0]        min_start;
        logic                    seq_error;
    } t_result;

endpackage

`default_nettype wire

@@ design/wsmm_cell.sv @@
`default_nettype none

module wsmm_cell
    import wsmm_pkg::*;
(
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_shift,
    input  wire                 i_clear,
    input  wire                 i_sel,
    input  wire  [SAMPLE_W-1:0] i_din,
    output logic [SAMPLE_W-1:0] o_dout,
    output logic [SAMPLE_W-1:0] o_tap
);

    logic [SAMPLE_W-1:0] r_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_data <= '0;
        end else if (i_clear) begin
            r_data <= '0;
        end else if (i_shift) begin
            r_data <= i_din;
        end
    end

    assign o_dout = r_data;
    assign o_tap  = i_sel ? r_data : '0;

endmodule

`default_nettype wire

@@ design/wsmm_chain.sv @@
`default_nettype none

module wsmm_chain
    import wsmm_pkg::*;
#(
    parameter int DEPTH = 64,
    parameter int LW    = 7
) (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_shift,
    input  wire                 i_clear,
    input  wire  [LW-1:0]       i_len,
    input  wire  [SAMPLE_W-1:0] i_sample,
    output logic [SAMPLE_W-1:0] o_tap
);

    logic [SAMPLE_W-1:0] cell_in  [DEPTH];
    logic [SAMPLE_W-1:0] cell_out [DEPTH];
    logic [SAMPLE_W-1:0] cell_tap [DEPTH];
    logic [DEPTH-1:0]    sel;

    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        // the sample leaving the window sits in cell len-1
        assign sel[g] = (i_len == LW'(g + 1));

        if (g == 0) begin : g_head
            assign cell_in[g] = i_sample;
        end else begin : g_body
            assign cell_in[g] = cell_out[g-1];
        end

        wsmm_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_shift (i_shift),
            .i_clear (i_clear),
            .i_sel   (sel[g]),
            .i_din   (cell_in[g]),
            .o_dout  (cell_out[g]),
            .o_tap   (cell_tap[g])
        );
    end

    always_comb begin
        o_tap = '0;
        for (int k = 0; k < DEPTH; k++) begin
            o_tap = o_tap | cell_tap[k];
        end
    end

endmodule

`default_nettype wire

@@ design/wsmm_extrema.sv @@
`default_nettype none

module wsmm_extrema
    import wsmm_pkg::*;
(
    input  wire        i_clk,
    input  wire        i_rst_n,
    input  wire        i_go,
    input  wire t_win_item i_item,
    output logic       o_load,
    output t_result    o_res
);

    logic                    r_have;
    logic signed [SUM_W-1:0] r_high;
    logic [POS_W-1:0]        r_high_pos;
    logic signed [SUM_W-1:0] r_low;
    logic [POS_W-1:0]        r_low_pos;

    logic                    n_have;
    logic signed [SUM_W-1:0] n_high;
    logic [POS_W-1:0]        n_high_pos;
    logic signed [SUM_W-1:0] n_low;
    logic [POS_W-1:0]        n_low_pos;
    logic                    upd_high;
    logic                    upd_low;

    // earliest window keeps the maximum, latest window takes the minimum
    assign upd_high = i_item.win && (!r_have || ($signed(i_item.sum) > $signed(r_high)));
    assign upd_low  = i_item.win && (!r_have || ($signed(i_item.sum) <= $signed(r_low)));

    always_comb begin
        n_have     = r_have | i_item.win;
        n_high     = upd_high ? i_item.sum   : r_high;
        n_high_pos = upd_high ? i_item.start : r_high_pos;
        n_low      = upd_low  ? i_item.sum   : r_low;
        n_low_pos  = upd_low  ? i_item.start : r_low_pos;
    end

    assign o_load = i_go && i_item.last;

    always_comb begin
        o_res.max_sum   = n_have ? n_high     : '0;
        o_res.max_start = n_have ? n_high_pos : '0;
        o_res.min_sum   = n_have ? n_low      : '0;
        o_res.min_start = n_have ? n_low_pos  : '0;
        o_res.seq_error = i_item.err;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_have     <= 1'b0;
            r_high     <= '0;
            r_high_pos <= '0;
            r_low      <= '0;
            r_low_pos  <= '0;
        end else if (i_go) begin
            if (i_item.last) begin
                r_have     <= 1'b0;
                r_high     <= '0;
                r_high_pos <= '0;
                r_low      <= '0;
                r_low_pos  <= '0;
            end else begin
                r_have     <= n_have;
                r_high     <= n_high;
                r_high_pos <= n_high_pos;
                r_low      <= n_low;
                r_low_pos  <= n_low_pos;
            end
        end
    end

endmodule

`default_nettype wire

@@ design/window_sum_max_min.sv @@
// sliding window sum extremes over one sequence of signed samples
//
// s_axis carries one sample a word, tlast marks the final sample of a sequence.
// m_axis gives one word per sequence, after the word marked last: the largest
// window sum with the start of the first window reaching it, the smallest sum
// with the start of the last window reaching it, and an error flag in tuser.
// i_cfg_wen/i_cfg_wdata write the window length; the user must write it
// only while the block is idle, which the block itself does not enforce.
// one sample is taken every cycle while s_axis_tready is high. the
// running sum is updated on the accepting edge from the sample leaving a
// row of shift cells and registered with the window flags; the extremes
// are compared from that register and the result is registered for m_axis.
// when the receiver stalls, the result waits in the output register and
// input keeps flowing until a second last-marked sample needs that register.
//
// reset (synchronous, active low) sets the window length to two, clears the
// shift cells, running sum, sample count and extremes, and empties the output.
`default_nettype none

module window_sum_max_min
    import wsmm_pkg::*;
#(
    parameter int MAX_WINDOW = 64,
    parameter int MAX_LENGTH = 65536
) (
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    input  wire                    i_cfg_wen,
    input  wire  [CFG_W-1:0]       i_cfg_wdata,
    input  wire                    s_axis_tvalid,
    output logic                   s_axis_tready,
    input  wire  [SAMPLE_W-1:0]    s_axis_tdata,   // [15:0] sample
    input  wire                    s_axis_tlast,   // is_last
    output logic                   m_axis_tvalid,
    input  wire                    m_axis_tready,
    // [21:0] max_sum, [37:22] max_start, [59:38] min_sum, [75:60] min_start
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,
    output logic                   m_axis_tuser    // seq_error
);

    localparam int LW_RAW = $clog2(MAX_WINDOW + 1);
    localparam int LW     = (LW_RAW > CFG_W) ? LW_RAW : CFG_W;
    localparam int CW     = $clog2(MAX_LENGTH + 2);
    localparam int XW0    = (LW > CW) ? LW : CW;
    localparam int XW     = ((XW0 > POS_W) ? XW0 : POS_W) + 1;

    logic [CFG_W-1:0]        r_window_len;
    logic signed [SUM_W-1:0] r_sum;
    logic [CW-1:0]           r_count;
    t_win_item               r_b;
    logic                    r_out_valid;
    t_result                 r_out;

    logic [LW-1:0]           len_cfg;
    logic [LW-1:0]           len;
    logic [CW-1:0]           n_count;
    logic                    tracked;
    logic [XW-1:0]           cnt_x;
    logic [XW-1:0]           len_x;
    logic [SAMPLE_W-1:0]     tap;
    logic signed [SUM_W-1:0] n_sum;
    logic                    acc;
    logic                    b_go;
    logic                    res_load;
    t_result                 res;

    // window length clamped into the range the cells support
    assign len_cfg = LW'(r_window_len);

    always_comb begin
        priority if (len_cfg < LW'(LEN_MIN)) begin
            len = LW'(LEN_MIN);
        end else if (len_cfg > LW'(MAX_WINDOW)) begin
            len = LW'(MAX_WINDOW);
        end else begin
            len = len_cfg;
        end
    end

    // count saturates one above the longest tracked sequence
    assign n_count = (r_count <= CW'(MAX_LENGTH)) ? r_count + CW'(1) : r_count;
    assign tracked = (n_count <= CW'(MAX_LENGTH));
    assign cnt_x   = XW'(n_count);
    assign len_x   = XW'(len);

    assign n_sum = r_sum
                 + {{(SUM_W - SAMPLE_W){s_axis_tdata[SAMPLE_W-1]}}, s_axis_tdata}
                 - {{(SUM_W - SAMPLE_W){tap[SAMPLE_W-1]}}, tap};

    assign b_go          = !r_b.valid || !r_b.last || !r_out_valid || m_axis_tready;
    assign s_axis_tready = b_go;
    assign acc           = s_axis_tvalid && s_axis_tready;

    wsmm_chain #(
        .DEPTH (MAX_WINDOW),
        .LW    (LW)
    ) u_chain (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_shift  (acc && tracked),
        .i_clear  (acc && s_axis_tlast),
        .i_len    (len),
        .i_sample (s_axis_tdata),
        .o_tap    (tap)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window_len <= CFG_W'(CFG_RESET);
        end else if (i_cfg_wen) begin
            r_window_len <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum   <= '0;
            r_count <= '0;
        end else if (acc) begin
            if (s_axis_tlast) begin
                r_sum   <= '0;
                r_count <= '0;
            end else begin
                r_count <= n_count;
                if (tracked) begin
                    r_sum <= n_sum;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b.valid <= 1'b0;
        end else if (acc) begin
            r_b.valid <= 1'b1;
        end else if (b_go) begin
            r_b.valid <= 1'b0;
        end
        if (acc) begin
            r_b.last  <= s_axis_tlast;
            r_b.err   <= (cnt_x < len_x + XW'(1)) || !tracked;
            r_b.win   <= tracked && (cnt_x >= len_x);
            r_b.start <= POS_W'(cnt_x - len_x);
            r_b.sum   <= n_sum;
        end
    end

    wsmm_extrema u_extrema (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_go    (r_b.valid && b_go),
        .i_item  (r_b),
        .o_load  (res_load),
        .o_res   (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_load) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_load) begin
            r_out <= res;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {{(OUT_TDATA_W - OUT_FIELD_W){1'b0}},
                            r_out.min_start, r_out.min_sum,
                            r_out.max_start, r_out.max_sum};
    assign m_axis_tuser  = r_out.seq_error;

endmodule

`default_nettype wire
